[rtl/nesd_pkg.sv]
// nesd_pkg: shared types, register indexes, result kinds and widths
// for the neutron event stream decoder.
// No dependencies; every other file of the decoder uses it.
package nesd_pkg;

    localparam int TIME_WIDTH  = 48;  // default width of the running time
    localparam int DELTA_W     = 32;
    localparam int TOF_W       = 48;
    localparam int DROP_W      = 32;
    localparam int TUBE_W      = 9;
    localparam int POS_W       = 8;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TUSER_W = KIND_W;
    localparam int OUT_FIELDS_W = TUBE_W + POS_W + TOF_W + DROP_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 2'd2;

    // register reset values
    localparam logic [7:0] HEADER_BYTES_RST   = 8'd128;
    localparam logic [8:0] TUBE_LIMIT_RST     = 9'd240;
    localparam logic [8:0] POSITION_LIMIT_RST = 9'd256;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

    localparam logic [7:0]         CONT_MASK   = 8'hC0;
    localparam logic [7:0]         LOW6_MASK   = 8'h3F;
    localparam logic [DELTA_W-1:0] FRAME_DELTA = 32'hFFFF_FFFF;
    localparam logic [DROP_W-1:0]  DROP_MAX    = 32'hFFFF_FFFF;
    localparam logic [2:0]         PHASE_LAST  = 3'd7;

    typedef struct packed {
        logic [7:0] header_bytes;
        logic [8:0] tube_limit;
        logic [8:0] position_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TUBE_W-1:0]  tube;
        logic [POS_W-1:0]   position;
        logic [TOF_W-1:0]   tof_ticks;
        logic [DROP_W-1:0]  dropped_total;
    } t_result;

endpackage

[rtl/neutron_event_stream_decoder.sv]
// neutron_event_stream_decoder: top level, byte stream in, decoded events out.
// Depends on nesd_pkg, nesd_cfg_regs, nesd_in_reg, nesd_decode.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: start_of_file
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: tube, position, tof_ticks,
//                                                    dropped_total; tuser: kind
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One byte per cycle while the output is not stalled; a byte's result goes through the input
// register, then the decode logic into the result register.
// The decode path is one byte's field merge followed by a TIME_W-bit add.
// Reset (synchronous, active low) restores register defaults and clears all decoder state.
// A stalled output holds its result; the input register keeps taking bytes while
// the result register can be emptied or refilled in the same cycle.
module neutron_event_stream_decoder #(
    parameter int TIME_WIDTH = nesd_pkg::TIME_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nesd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic [nesd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // [0] start_of_file
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [8:0] tube, [16:9] position, [64:17] tof_ticks, [96:65] dropped_total, rest zero
    output logic [nesd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [nesd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,   // [1:0] kind
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nesd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nesd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PadW = nesd_pkg::OUT_TDATA_W - nesd_pkg::OUT_FIELDS_W;

    nesd_pkg::t_cfg    cfg;
    nesd_pkg::t_item   in_item;
    nesd_pkg::t_item   reg_item;
    nesd_pkg::t_result result;
    logic              reg_valid;
    logic              dec_ready;

    assign in_item.data_byte     = s_axis_tdata;
    assign in_item.start_of_file = s_axis_tuser[0];

    nesd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    nesd_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .o_valid    (reg_valid),
        .i_dn_ready (dec_ready),
        .o_item     (reg_item)
    );

    nesd_decode #(
        .TIME_W (TIME_WIDTH)
    ) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (reg_valid),
        .o_ready    (dec_ready),
        .i_item     (reg_item),
        .o_valid    (m_axis_tvalid),
        .i_dn_ready (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {{PadW{1'b0}}, result.dropped_total, result.tof_ticks,
                           result.position, result.tube};
    assign m_axis_tuser = result.kind;

endmodule

[rtl/nesd_cfg_regs.sv]
// nesd_cfg_regs: configuration registers (header length, tube and position limits).
// Depends on nesd_pkg.
module nesd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nesd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nesd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output nesd_pkg::t_cfg                   o_cfg
);

    nesd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_bytes   <= nesd_pkg::HEADER_BYTES_RST;
            r_cfg.tube_limit     <= nesd_pkg::TUBE_LIMIT_RST;
            r_cfg.position_limit <= nesd_pkg::POSITION_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nesd_pkg::CFG_HEADER_BYTES:   r_cfg.header_bytes   <= i_cfg_data[7:0];
                nesd_pkg::CFG_TUBE_LIMIT:     r_cfg.tube_limit     <= i_cfg_data;
                nesd_pkg::CFG_POSITION_LIMIT: r_cfg.position_limit <= i_cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

endmodule

[rtl/nesd_in_reg.sv]
// nesd_in_reg: input register stage, holds one byte while the decode stage is busy.
// Depends on nesd_pkg.
module nesd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nesd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_dn_ready,
    output nesd_pkg::t_item o_item
);

    logic            r_valid;
    nesd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_dn_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/nesd_decode.sv]
// nesd_decode: per-byte event decoder, time accumulator, drop counter and result register.
// Depends on nesd_pkg.
module nesd_decode #(
    parameter int TIME_W = nesd_pkg::TIME_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nesd_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  nesd_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_dn_ready,
    output nesd_pkg::t_result o_result
);

    localparam int TofW  = nesd_pkg::TOF_W;
    localparam int SextW = TIME_W - nesd_pkg::DELTA_W;

    // bit position of the low bit for continuation bytes 3..7
    function automatic logic [4:0] delta_shift(input logic [2:0] phase);
        logic [4:0] s;
        begin
            case (phase)
                3'd3:    s = 5'd5;
                3'd4:    s = 5'd11;
                3'd5:    s = 5'd17;
                3'd6:    s = 5'd23;
                3'd7:    s = 5'd29;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    logic [2:0]                      r_phase, n_phase;
    logic [7:0]                      r_hdr_cnt, n_hdr_cnt;
    logic [nesd_pkg::TUBE_W-1:0]     r_tube, n_tube;
    logic [nesd_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [nesd_pkg::DELTA_W-1:0]    r_delta, n_delta;
    logic [TIME_W-1:0]               r_time, n_time;
    logic [nesd_pkg::DROP_W-1:0]     r_drop, n_drop;
    logic                            r_out_valid;
    nesd_pkg::t_result               r_result, n_result;

    logic                            fire;
    logic                            produce;
    logic [2:0]                      phase_base;
    logic [7:0]                      hdr_base;
    logic [TIME_W-1:0]               time_base;
    logic                            in_header;
    logic                            cont;
    logic [7:0]                      c_eff;
    logic                            ended;
    logic [nesd_pkg::KIND_W-1:0]     kind;

    assign o_ready  = !r_out_valid || i_dn_ready;
    assign fire     = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        // start of file clears the phase, header count and time before the byte is handled
        phase_base = i_item.start_of_file ? 3'd0 : r_phase;
        hdr_base   = i_item.start_of_file ? 8'd0 : r_hdr_cnt;
        time_base  = i_item.start_of_file ? '0 : r_time;
        in_header  = hdr_base < i_cfg.header_bytes;
        cont       = (i_item.data_byte & nesd_pkg::CONT_MASK) == nesd_pkg::CONT_MASK;
        c_eff      = cont ? (i_item.data_byte & nesd_pkg::LOW6_MASK) : i_item.data_byte;

        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_tube    = r_tube;
        n_pos     = r_pos;
        n_delta   = r_delta;
        n_time    = r_time;
        n_drop    = r_drop;
        ended     = 1'b0;
        produce   = 1'b0;
        kind      = nesd_pkg::KIND_EVENT;

        if (fire) begin
            n_phase   = phase_base;
            n_hdr_cnt = hdr_base;
            n_time    = time_base;
            if (in_header) begin
                n_hdr_cnt = hdr_base + 8'd1;
            end else begin
                case (phase_base)
                    3'd0: n_tube = {1'b0, i_item.data_byte};
                    3'd1: begin
                        n_tube = {i_item.data_byte[0], r_tube[7:0]};
                        n_pos  = {1'b0, i_item.data_byte[7:1]};
                    end
                    3'd2: begin
                        ended   = !cont;
                        n_pos   = {c_eff[0], r_pos[6:0]};
                        n_delta = {25'd0, c_eff[7:1]};
                    end
                    default: begin
                        ended   = !cont;
                        n_delta = r_delta | (32'(c_eff) << delta_shift(phase_base));
                    end
                endcase

                if (ended || phase_base == nesd_pkg::PHASE_LAST) begin
                    n_phase = 3'd0;
                    produce = 1'b1;
                    if (n_tube == '0 && n_pos == '0 && n_delta == nesd_pkg::FRAME_DELTA) begin
                        n_time = '0;
                        kind   = nesd_pkg::KIND_FRAME;
                    end else begin
                        n_time = time_base + {{SextW{n_delta[nesd_pkg::DELTA_W-1]}}, n_delta};
                        if (n_tube >= i_cfg.tube_limit || {1'b0, n_pos} >= i_cfg.position_limit) begin
                            kind = nesd_pkg::KIND_DROP;
                            if (r_drop != nesd_pkg::DROP_MAX) begin
                                n_drop = r_drop + 32'd1;
                            end
                        end
                    end
                end else begin
                    n_phase = phase_base + 3'd1;
                end
            end
        end

        n_result.kind          = kind;
        n_result.tube          = n_tube;
        n_result.position      = n_pos;
        n_result.tof_ticks     = TofW'(n_time);
        n_result.dropped_total = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_hdr_cnt   <= '0;
            r_tube      <= '0;
            r_pos       <= '0;
            r_delta     <= '0;
            r_time      <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_tube    <= n_tube;
            r_pos     <= n_pos;
            r_delta   <= n_delta;
            r_time    <= n_time;
            r_drop    <= n_drop;
            if (fire) begin
                r_out_valid <= produce;
            end else if (i_dn_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && produce) begin
            r_result <= n_result;
        end
    end

endmodule

[rtl/nesd_checker.sv]
// nesd_checker: port-level checks on the decoder's stream channels, bound to the top level.
// Depends on nesd_pkg and neutron_event_stream_decoder.
module nesd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [nesd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [nesd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // new-frame result carries zero tube, position and time
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == nesd_pkg::KIND_FRAME |->
            m_axis_tdata[64:0] == '0)
        else $error("frame marker with nonzero fields");

    // input never blocked when the output side can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free result register");

    // a fresh result follows an input transfer through the input and result registers
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding input transfer");

endmodule

bind neutron_event_stream_decoder nesd_checker u_nesd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[test/neutron_event_stream_decoder_tb.sv]
// Self-checking testbench for neutron_event_stream_decoder: byte stream in, decoded events out.
// Depends on nesd_pkg and the decoder RTL; expected events come from a predictor kept here.
`timescale 1ns / 100ps

module neutron_event_stream_decoder_tb;

    // not mapped, writes dropped
    localparam logic [nesd_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [nesd_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [nesd_pkg::IN_TUSER_W-1:0]     s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [nesd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [nesd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [nesd_pkg::CFG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [nesd_pkg::CFG_DATA_W-1:0]     i_cfg_data    = '0;

    neutron_event_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct {
        logic [7:0]        data;
        bit                sof;
        bit                typed;
        nesd_pkg::t_result want;
    } t_row;

    // decoder mirror
    nesd_pkg::t_cfg                  cfg_q;
    logic [3:0]                      phase_q;
    logic [nesd_pkg::TUBE_W-1:0]     tube_q;
    logic [nesd_pkg::POS_W-1:0]      pos_q;
    logic [nesd_pkg::DELTA_W-1:0]    delta_q;
    logic [nesd_pkg::TOF_W-1:0]      tof_q;
    logic [7:0]                      hdr_cnt;
    logic [nesd_pkg::DROP_W-1:0]     drop_q;
    int                              sent_bytes = 0;

    nesd_pkg::t_result pending_events[$];
    t_row              dir_rows[$];
    int                err_count    = 0;
    int                results_seen = 0;
    bit                src_quiet    = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("neutron_event_stream_decoder_tb: errors");
        $finish;
    end

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            log_error($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
    endtask

    // One byte through the decoder; returns the event it completes, if any.
    function automatic void decode_byte(input logic [7:0] raw, input logic sof,
                                        output bit emits, output nesd_pkg::t_result res);
        logic [7:0]                   b;
        logic [nesd_pkg::DELTA_W-1:0] part;
        bit                           last_byte;
        b         = raw;
        last_byte = 1'b0;
        emits     = 1'b0;
        res       = '0;
        if (sof) begin
            phase_q = '0;
            tube_q  = '0;
            pos_q   = '0;
            delta_q = '0;
            tof_q   = '0;
            hdr_cnt = '0;
        end
        if (hdr_cnt < cfg_q.header_bytes) begin
            hdr_cnt = hdr_cnt + 8'd1;
            return;
        end
        // from the third byte on, top bits 11 mean more to come and only 6 bits count
        if (phase_q >= 4'd2) begin
            last_byte = (b & nesd_pkg::CONT_MASK) != nesd_pkg::CONT_MASK;
            if (!last_byte) b = b & nesd_pkg::LOW6_MASK;
        end
        part = {{(nesd_pkg::DELTA_W-8){1'b0}}, b};
        case (phase_q)
            4'd0: tube_q = {1'b0, b};
            4'd1: begin
                tube_q[8] = b[0];
                pos_q     = {1'b0, b[7:1]};
            end
            4'd2: begin
                pos_q[7] = b[0];
                delta_q  = part >> 1;
            end
            default: delta_q = delta_q | (part << (5 + 6 * (phase_q - 4'd3)));
        endcase
        phase_q = phase_q + 4'd1;
        if (!last_byte && phase_q != 4'd8) return;
        phase_q = '0;
        if (tube_q == '0 && pos_q == '0 && delta_q == nesd_pkg::FRAME_DELTA) begin
            tof_q    = '0;
            res.kind = nesd_pkg::KIND_FRAME;
        end else begin
            tof_q = tof_q + {{(nesd_pkg::TOF_W-nesd_pkg::DELTA_W){delta_q[nesd_pkg::DELTA_W-1]}},
                             delta_q};
            if (tube_q >= cfg_q.tube_limit || {1'b0, pos_q} >= cfg_q.position_limit) begin
                if (drop_q != nesd_pkg::DROP_MAX) drop_q = drop_q + 1'b1;
                res.kind = nesd_pkg::KIND_DROP;
            end else begin
                res.kind = nesd_pkg::KIND_EVENT;
            end
        end
        res.tube          = tube_q;
        res.position      = pos_q;
        res.tof_ticks     = tof_q;
        res.dropped_total = drop_q;
        emits             = 1'b1;
    endfunction

    task automatic add_row(input logic [7:0] data, input bit sof,
                           input bit typed = 1'b0, input nesd_pkg::t_result want = '0);
        t_row r;
        r.data  = data;
        r.sof   = sof;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    // Offer one byte, wait for the transfer, then maybe idle.
    task automatic push_byte(input logic [7:0] b, input bit sof,
                             input bit typed = 1'b0, input nesd_pkg::t_result want = '0);
        bit                emits;
        nesd_pkg::t_result res;
        int                gap;
        int                r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        sent_bytes++;
        decode_byte(b, sof, emits, res);
        if (emits) pending_events.push_back(typed ? want : res);
        gap = 0;
        if (!src_quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 95)      gap = $urandom_range(8, 40);
            else if (r >= 75) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [nesd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nesd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            nesd_pkg::CFG_HEADER_BYTES:   cfg_q.header_bytes   = val[7:0];
            nesd_pkg::CFG_TUBE_LIMIT:     cfg_q.tube_limit     = val;
            nesd_pkg::CFG_POSITION_LIMIT: cfg_q.position_limit = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the input until every expected event is out and the pipe has emptied.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Finish any partial event so the next one starts on a boundary.
    task automatic realign();
        while (phase_q != 4'd0) push_byte(8'($urandom_range(0, 63)), 1'b0);
    endtask

    task automatic start_file();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < cfg_q.header_bytes; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_event();
        int         len;
        logic [7:0] b;
        realign();
        len = $urandom_range(3, 8);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        for (int k = 2; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            if (k < len - 1)
                b[7:6] = 2'b11;
            else if (k < 7 && b[7:6] == 2'b11)
                b[7] = 1'b0;
            push_byte(b, 1'b0);
        end
    endtask

    // Frame marker; a corrupted one has one bit flipped somewhere.
    task automatic send_frame(input bit corrupt);
        logic [7:0] fb [8];
        int         n;
        realign();
        fb[0] = 8'h00;
        fb[1] = 8'h00;
        fb[2] = 8'hFE;
        for (int i = 3; i < 7; i++) fb[i] = 8'hFF;
        fb[7] = 8'($urandom_range(0, 255)) | 8'h07;
        if (corrupt) begin
            n = $urandom_range(0, 7);
            fb[n][$urandom_range(0, 7)] ^= 1'b1;
        end
        for (int i = 0; i < 8; i++) push_byte(fb[i], 1'b0);
    endtask

    task automatic run_phase(input bit reprogram, input bit sof_first,
                             input int hdr, input int tube, input int pos, input bit tail);
        int goal;
        int pick;
        if (reprogram) begin
            write_reg(nesd_pkg::CFG_HEADER_BYTES,
                      {$urandom_range(0, 1) == 1, 8'(hdr < 0 ? $urandom_range(0, 255) : hdr)});
            write_reg(nesd_pkg::CFG_TUBE_LIMIT, 9'(tube < 0 ? $urandom_range(0, 511) : tube));
            write_reg(nesd_pkg::CFG_POSITION_LIMIT, 9'(pos < 0 ? $urandom_range(0, 511) : pos));
            write_reg(CFG_SPARE_INDEX, 9'($urandom_range(0, 511)));
        end
        src_quiet = ($urandom_range(0, 3) == 0);
        if (sof_first) start_file();
        goal = sent_bytes + 60;
        while (sent_bytes < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_event();
            end else if (pick < 73) begin
                send_frame(1'b0);
            end else if (pick < 80) begin
                send_frame(1'b1);
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 97) begin
                start_file();
            end else begin
                // broken event cut short by a new file
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                start_file();
            end
        end
        // leave the next phase sitting part way into a header
        if (tail) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat (5) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        settle();
    endtask

    task automatic take_result();
        nesd_pkg::t_result got;
        nesd_pkg::t_result want;
        got.kind          = m_axis_tuser;
        got.tube          = m_axis_tdata[nesd_pkg::TUBE_W-1:0];
        got.position      = m_axis_tdata[nesd_pkg::TUBE_W +: nesd_pkg::POS_W];
        got.tof_ticks     = m_axis_tdata[nesd_pkg::TUBE_W+nesd_pkg::POS_W +: nesd_pkg::TOF_W];
        got.dropped_total = m_axis_tdata[nesd_pkg::TUBE_W+nesd_pkg::POS_W+nesd_pkg::TOF_W +:
                                         nesd_pkg::DROP_W];
        results_seen++;
        if (pending_events.size() == 0) begin
            log_error($sformatf("unexpected result: kind %0d tube %0d position %0d",
                                got.kind, got.tube, got.position));
            return;
        end
        want = pending_events.pop_front();
        cmp_field("kind", 64'(got.kind), 64'(want.kind));
        cmp_field("tube", 64'(got.tube), 64'(want.tube));
        cmp_field("position", 64'(got.position), 64'(want.position));
        cmp_field("tof_ticks", 64'(got.tof_ticks), 64'(want.tof_ticks));
        cmp_field("dropped_total", 64'(got.dropped_total), 64'(want.dropped_total));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) take_result();
    end

    // Output side: random stalls, quiet stretches and two long hold-offs.
    initial begin : sink_ready
        int stall_left = 0;
        int hold_left  = 0;
        int mode_left  = 0;
        int holds_done = 0;
        bit quiet      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                quiet     = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(200, 800);
            end
            mode_left--;
            if (holds_done < 2 && results_seen >= (holds_done == 0 ? 30 : 80)) begin
                hold_left = 400;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 39)
                                                          : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        cfg_q   = nesd_pkg::t_cfg'{nesd_pkg::HEADER_BYTES_RST, nesd_pkg::TUBE_LIMIT_RST,
                                   nesd_pkg::POSITION_LIMIT_RST};
        phase_q = '0;
        tube_q  = '0;
        pos_q   = '0;
        delta_q = '0;
        tof_q   = '0;
        hdr_cnt = '0;
        drop_q  = '0;

        // reset-default limits; every event completes on its last row
        for (int i = 0; i < 7; i++) add_row(i < 2 ? 8'h00 : (i == 2 ? 8'hFE : 8'hFF), 1'b0);
        add_row(8'hFF, 1'b0, 1'b1,
                nesd_pkg::t_result'{nesd_pkg::KIND_FRAME, 9'd0, 8'd0, 48'd0, 32'd0});
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0, 1'b1,
                nesd_pkg::t_result'{nesd_pkg::KIND_EVENT, 9'd0, 8'd0, 48'd0, 32'd0});
        // largest tube and position
        add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h01, 1'b0, 1'b1,
                nesd_pkg::t_result'{nesd_pkg::KIND_DROP, 9'd511, 8'd255, 48'd0, 32'd1});
        // eight-byte event, delta of -1
        add_row(8'h05, 1'b0);
        add_row(8'h06, 1'b0);
        add_row(8'hFE, 1'b0);
        for (int i = 0; i < 4; i++) add_row(8'hFF, 1'b0);
        add_row(8'h07, 1'b0, 1'b1,
                nesd_pkg::t_result'{nesd_pkg::KIND_EVENT, 9'd5, 8'd3, 48'hFFFF_FFFF_FFFF,
                                    32'd1});
        // four-byte event ending on a full byte
        add_row(8'h10, 1'b0);
        add_row(8'h20, 1'b0);
        add_row(8'hC2, 1'b0);
        add_row(8'h3F, 1'b0);
        // new file in the middle of an event
        add_row(8'h33, 1'b0);
        add_row(8'h44, 1'b1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default header length: the file start plus 127 skipped bytes
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (127) push_byte(8'($urandom_range(0, 255)), 1'b0);
        foreach (dir_rows[i])
            push_byte(dir_rows[i].data, dir_rows[i].sof, dir_rows[i].typed, dir_rows[i].want);
        settle();

        run_phase(1'b1, 1'b0, 0, 511, 256, 1'b0);
        run_phase(1'b1, 1'b1, 255, 0, 0, 1'b0);
        run_phase(1'b1, 1'b1, 200, 240, 128, 1'b1);
        run_phase(1'b1, 1'b0, 2, 300, 200, 1'b0);
        run_phase(1'b0, 1'b0, 0, 0, 0, 1'b0);
        run_phase(1'b1, 1'b1, -1, -1, -1, 1'b0);
        run_phase(1'b1, 1'b1, 0, 1, 1, 1'b0);
        run_phase(1'b1, 1'b1, -1, 511, 255, 1'b0);
        run_phase(1'b1, 1'b0, -1, -1, -1, 1'b0);

        if (err_count == 0) begin
            $display("neutron_event_stream_decoder_tb: clean");
        end else begin
            $display("neutron_event_stream_decoder_tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/nesd_pkg.sv
rtl/nesd_cfg_regs.sv
rtl/nesd_in_reg.sv
rtl/nesd_decode.sv
rtl/neutron_event_stream_decoder.sv
rtl/nesd_checker.sv
test/neutron_event_stream_decoder_tb.sv
